// ===== hdl/tbpr_pkg.sv =====
package tbpr_pkg;

   // Sizing of the stores
   localparam int MAX_WINDOWS   = 8;
   localparam int TILE_COUNT    = 1024;
   localparam int PALETTE_BANKS = 16;
   localparam int COORD_BITS    = 12;

   localparam int MAP_DEPTH   = 1024;
   localparam int MAP_AW      = 10;
   localparam int TEXEL_DEPTH = TILE_COUNT * 32;
   localparam int TEXEL_AW    = $clog2(TEXEL_DEPTH);
   localparam int COLOR_DEPTH = PALETTE_BANKS * 16;
   localparam int COLOR_AW    = $clog2(COLOR_DEPTH);
   localparam int WIN_IW      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

   // Field widths fixed by the interface
   localparam int COORD_W     = 12;
   localparam int WIN_COUNT_W = 4;
   localparam int WIN_N_W     = 6;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

   // Request codes
   localparam logic [2:0] REQ_MAP_WR   = 3'd0;
   localparam logic [2:0] REQ_TEXEL_WR = 3'd1;
   localparam logic [2:0] REQ_COLOR_WR = 3'd2;
   localparam logic [2:0] REQ_WIN_WR   = 3'd3;
   localparam logic [2:0] REQ_RENDER   = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_X      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_Y      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_DISABLE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_COUNT  = 4'd3;

   // c * 255 / 31, truncated, for every 5-bit channel value
   localparam logic [7:0] EXPAND5_TABLE [0:31] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   typedef struct packed {
      logic [2:0]          req_type;
      logic [14:0]         mem_index;
      logic [15:0]         write_value;
      logic [11:0]         pixel_x;
      logic [11:0]         pixel_y;
      logic signed [15:0]  win_left;
      logic signed [15:0]  win_top;
      logic signed [15:0]  win_width;
      logic signed [15:0]  win_height;
   } req_item_type;

   typedef struct packed {
      logic [31:0] argb_color;
      logic        drawn;
   } rsp_item_type;

   typedef struct packed {
      logic                en;
      logic [WIN_IW-1:0]   idx;
      logic signed [15:0]  left;
      logic signed [15:0]  top;
      logic signed [15:0]  width;
      logic signed [15:0]  height;
   } win_wr_type;

endpackage

// ===== hdl/tbpr_ram.sv =====
module tbpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tbpr_window.sv =====
module tbpr_window import tbpr_pkg::*; (
   input  logic                    clock,
   input  win_wr_type              wr,
   input  logic [WIN_COUNT_W-1:0]  count,
   input  logic [COORD_W-1:0]      x,
   input  logic [COORD_W-1:0]      y,
   output logic                    hit
);

   logic signed [17:0] left_ff   [MAX_WINDOWS];
   logic signed [17:0] right_ff  [MAX_WINDOWS];
   logic signed [17:0] top_ff    [MAX_WINDOWS];
   logic signed [17:0] bottom_ff [MAX_WINDOWS];

   logic signed [17:0] left_in, right_in, top_in, bottom_in;
   logic signed [17:0] xs, ys;
   logic [WIN_N_W-1:0] n_eff;
   logic [MAX_WINDOWS-1:0] hit_vec;

   // Keep the far edges precomputed; an empty rectangle ends at or before its start
   always_comb begin
      left_in   = 18'(wr.left);
      top_in    = 18'(wr.top);
      right_in  = 18'(wr.left) + 18'(wr.width);
      bottom_in = 18'(wr.top) + 18'(wr.height);
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         left_ff[wr.idx]   <= left_in;
         right_ff[wr.idx]  <= right_in;
         top_ff[wr.idx]    <= top_in;
         bottom_ff[wr.idx] <= bottom_in;
      end
   end

   always_comb begin
      xs = signed'({6'b0, x});
      ys = signed'({6'b0, y});
      if ({2'b0, count} > WIN_N_W'(MAX_WINDOWS)) begin
         n_eff = WIN_N_W'(MAX_WINDOWS);
      end else begin
         n_eff = {2'b0, count};
      end
      for (int i = 0; i < MAX_WINDOWS; i++) begin
         hit_vec[i] = (WIN_N_W'(i) < n_eff) &&
                      (xs >= left_ff[i]) && (xs < right_ff[i]) &&
                      (ys >= top_ff[i]) && (ys < bottom_ff[i]);
      end
      hit = |hit_vec;
   end

endmodule

// ===== hdl/tile_background_pixel_renderer.sv =====
// A render item accepted at a clock edge passes the stage A, B, C and D registers into
// the output register, and its result shows on rsp_item with rsp_strobe high.
// Throughput: one item per clock; busy stays low, so start may be held high.
// Write items give no result. Every store sits at the stage that reads it.
// Reset (synchronous, active high) clears the registers and the item pipeline;
// busy is high during reset and the cycle after; the stores keep their contents.
module tile_background_pixel_renderer import tbpr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_item_type           req_item,
   output logic                   rsp_strobe,
   output rsp_item_type           rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0]             scroll_x_ff, scroll_y_ff;
   logic                   layer_disable_ff;
   logic [WIN_COUNT_W-1:0] window_count_ff;
   logic                   busy_ff;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff      <= '0;
         scroll_y_ff      <= '0;
         layer_disable_ff <= 1'b0;
         window_count_ff  <= '0;
         busy_ff          <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SCROLL_X:      scroll_x_ff      <= csr_wdata;
               CSR_SCROLL_Y:      scroll_y_ff      <= csr_wdata;
               CSR_LAYER_DISABLE: layer_disable_ff <= csr_wdata[0];
               CSR_WINDOW_COUNT:  window_count_ff  <= csr_wdata[WIN_COUNT_W-1:0];
               default: ;  // unknown register: drop the write
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage A: item registered; window test, scroll, tilemap access
   // ---------------------------------------------------------------
   logic         a_valid_ff, a_valid_in;
   req_item_type a_item_ff;

   assign a_valid_in = start && !busy_ff;

   always_ff @(posedge clock) begin
      a_item_ff <= req_item;
   end

   logic [COORD_W-1:0] a_x, a_y;
   logic [7:0]         a_sx, a_sy;
   logic               a_hit;
   logic               a_map_wr;
   win_wr_type         a_win_wr;

   always_comb begin
      a_x  = a_item_ff.pixel_x & COORD_MASK;
      a_y  = a_item_ff.pixel_y & COORD_MASK;
      // 8-bit scroll wraps at 256 pixels
      a_sx = a_x[7:0] + scroll_x_ff;
      a_sy = a_y[7:0] + scroll_y_ff;
      a_map_wr = a_valid_ff && (a_item_ff.req_type == REQ_MAP_WR) &&
                 (16'(a_item_ff.mem_index) < 16'(MAP_DEPTH));
      a_win_wr.en     = a_valid_ff && (a_item_ff.req_type == REQ_WIN_WR) &&
                        (16'(a_item_ff.mem_index) < 16'(MAX_WINDOWS));
      a_win_wr.idx    = a_item_ff.mem_index[WIN_IW-1:0];
      a_win_wr.left   = a_item_ff.win_left;
      a_win_wr.top    = a_item_ff.win_top;
      a_win_wr.width  = a_item_ff.win_width;
      a_win_wr.height = a_item_ff.win_height;
   end

   tbpr_window u_window (
      .clock (clock),
      .wr    (a_win_wr),
      .count (window_count_ff),
      .x     (a_x),
      .y     (a_y),
      .hit   (a_hit)
   );

   logic [15:0] map_rd_data;

   // 32x32 map: row from the scrolled y, column from the scrolled x
   tbpr_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map_ram (
      .clock   (clock),
      .wr_en   (a_map_wr),
      .wr_addr (a_item_ff.mem_index[MAP_AW-1:0]),
      .wr_data (a_item_ff.write_value),
      .rd_en   (a_valid_ff),
      .rd_addr ({a_sy[7:3], a_sx[7:3]}),
      .rd_data (map_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage B: decode map entry, flip, tile graphics access
   // ---------------------------------------------------------------
   logic        b_valid_ff;
   logic [2:0]  b_kind_ff;
   logic [14:0] b_index_ff;
   logic [15:0] b_value_ff;
   logic        b_hit_ff;
   logic [2:0]  b_tx_ff, b_ty_ff;

   always_ff @(posedge clock) begin
      b_kind_ff  <= a_item_ff.req_type;
      b_index_ff <= a_item_ff.mem_index;
      b_value_ff <= a_item_ff.write_value;
      b_hit_ff   <= a_hit;
      b_tx_ff    <= a_sx[2:0];
      b_ty_ff    <= a_sy[2:0];
   end

   logic [9:0]  b_tile;
   logic [3:0]  b_bank;
   logic [2:0]  b_tx, b_ty;
   logic        b_tile_ok;
   logic [14:0] b_taddr;
   logic        b_texel_wr;

   always_comb begin
      b_tile = map_rd_data[9:0];
      b_bank = map_rd_data[15:12];
      // 7 - t on three bits is the complement
      b_tx   = map_rd_data[10] ? ~b_tx_ff : b_tx_ff;
      b_ty   = map_rd_data[11] ? ~b_ty_ff : b_ty_ff;
      b_tile_ok = 11'(b_tile) < 11'(TILE_COUNT);
      // 32 bytes per tile, 4 bytes per row, two texels per byte
      b_taddr = {b_tile, b_ty, b_tx[2:1]};
      b_texel_wr = b_valid_ff && (b_kind_ff == REQ_TEXEL_WR) &&
                   (17'(b_index_ff) < 17'(TEXEL_DEPTH));
   end

   logic [7:0] texel_rd_data;

   tbpr_ram #(.WIDTH(8), .DEPTH(TEXEL_DEPTH)) u_texel_ram (
      .clock   (clock),
      .wr_en   (b_texel_wr),
      .wr_addr (b_index_ff[TEXEL_AW-1:0]),
      .wr_data (b_value_ff[7:0]),
      .rd_en   (b_valid_ff),
      .rd_addr (b_taddr[TEXEL_AW-1:0]),
      .rd_data (texel_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage C: pick the nibble, palette access, draw decision
   // ---------------------------------------------------------------
   logic        c_valid_ff;
   logic [2:0]  c_kind_ff;
   logic [14:0] c_index_ff;
   logic [14:0] c_value_ff;
   logic        c_hit_ff;
   logic        c_tile_ok_ff;
   logic [3:0]  c_bank_ff;
   logic        c_hi_ff;

   always_ff @(posedge clock) begin
      c_kind_ff    <= b_kind_ff;
      c_index_ff   <= b_index_ff;
      c_value_ff   <= b_value_ff[14:0];
      c_hit_ff     <= b_hit_ff;
      c_tile_ok_ff <= b_tile_ok;
      c_bank_ff    <= b_bank;
      c_hi_ff      <= b_tx[0];
   end

   logic [3:0] c_texel;
   logic [7:0] c_caddr;
   logic       c_bank_ok;
   logic       c_color_wr;
   logic       c_draw;
   logic       c_render;

   always_comb begin
      // low nibble is the left texel of a pair
      c_texel    = c_hi_ff ? texel_rd_data[7:4] : texel_rd_data[3:0];
      c_caddr    = {c_bank_ff, c_texel};
      c_bank_ok  = 5'(c_bank_ff) < 5'(PALETTE_BANKS);
      c_color_wr = c_valid_ff && (c_kind_ff == REQ_COLOR_WR) &&
                   (16'(c_index_ff) < 16'(COLOR_DEPTH));
      c_render   = c_valid_ff && (c_kind_ff == REQ_RENDER);
      c_draw     = !layer_disable_ff && c_hit_ff && c_tile_ok_ff && c_bank_ok &&
                   (c_texel != 4'd0);
   end

   logic [14:0] color_rd_data;

   tbpr_ram #(.WIDTH(15), .DEPTH(COLOR_DEPTH)) u_color_ram (
      .clock   (clock),
      .wr_en   (c_color_wr),
      .wr_addr (c_index_ff[COLOR_AW-1:0]),
      .wr_data (c_value_ff),
      .rd_en   (c_valid_ff),
      .rd_addr (c_caddr[COLOR_AW-1:0]),
      .rd_data (color_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage D: expand BGR555 to opaque ARGB8888, zero if not drawn, into output register
   // ---------------------------------------------------------------
   logic d_render_ff;
   logic d_draw_ff;

   always_ff @(posedge clock) begin
      d_draw_ff <= c_draw;
   end

   rsp_item_type d_item;

   always_comb begin
      if (d_draw_ff) begin
         d_item.argb_color = {8'hFF,
                              EXPAND5_TABLE[color_rd_data[4:0]],
                              EXPAND5_TABLE[color_rd_data[9:5]],
                              EXPAND5_TABLE[color_rd_data[14:10]]};
         d_item.drawn      = 1'b1;
      end else begin
         d_item.argb_color = '0;
         d_item.drawn      = 1'b0;
      end
   end

   logic         rsp_strobe_ff;
   rsp_item_type rsp_item_ff;

   always_ff @(posedge clock) begin
      rsp_item_ff <= d_item;
   end

   // Advance the valid bits; reset empties the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_render_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= a_valid_ff;
         c_valid_ff    <= b_valid_ff;
         d_render_ff   <= c_render;
         rsp_strobe_ff <= d_render_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ===== hdl/tbpr_checker.sv =====
module tbpr_checker import tbpr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_strobe,
   input rsp_item_type rsp_item
);

   logic render_acc;

   assign render_acc = start && !busy && (req_item.req_type == REQ_RENDER);

   // every accepted render item gives one result
   a_render_result: assert property (@(posedge clock) disable iff (reset)
      render_acc |-> ##5 rsp_strobe)
      else $error("render item without result");

   // no result without a render item at the matching edge
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(render_acc, 5))
      else $error("result without render item");

   a_drawn_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.drawn) |-> (rsp_item.argb_color[31:24] == 8'hFF))
      else $error("drawn pixel not opaque");

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.drawn) |-> (rsp_item.argb_color == 32'd0))
      else $error("transparent pixel not zero");

endmodule

bind tile_background_pixel_renderer tbpr_checker u_checker (.*);
